>>> src/prhm_pkg.sv
// Shared types and constants for the pulse rate hysteresis meter.
package prhm_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int LEVEL_BITS  = 10;
	localparam int SPM_BITS    = 12;
	localparam int RATE_BITS   = 16;
	localparam int COUNT_BITS  = 16;
	localparam int CFG_BITS    = 12;
	localparam int ADDR_BITS   = 2;
	localparam int CMP_BITS    = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
	localparam int STEP_BITS   = $clog2(RATE_BITS);

	localparam logic [LEVEL_BITS-1:0] RISE_RESET = LEVEL_BITS'(124);
	localparam logic [LEVEL_BITS-1:0] FALL_RESET = LEVEL_BITS'(63);
	localparam logic [SPM_BITS-1:0]   SPM_RESET  = SPM_BITS'(600);
	localparam logic [RATE_BITS-1:0]  RATE_MAX   = {RATE_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [STEP_BITS-1:0]  LAST_STEP  = STEP_BITS'(RATE_BITS - 1);

	typedef enum logic [ADDR_BITS-1:0] {
		REG_RISE = 2'd0,
		REG_FALL = 2'd1,
		REG_SPM  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> src/prhm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module prhm_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              ack,
	input  logic [prhm_pkg::RATE_BITS-1:0]    num,
	input  logic [prhm_pkg::COUNT_BITS-1:0]   den,
	output prhm_pkg::div_stat_t               stat,
	output logic [prhm_pkg::RATE_BITS-1:0]    quo
);

	prhm_pkg::div_state_t state_q, state_d;

	logic [prhm_pkg::STEP_BITS-1:0]  step_q;
	logic [prhm_pkg::COUNT_BITS-1:0] rem_q;
	logic [prhm_pkg::RATE_BITS-1:0]  quo_q;
	logic [prhm_pkg::COUNT_BITS-1:0] den_q;

	logic [prhm_pkg::COUNT_BITS:0]   shifted;
	logic [prhm_pkg::COUNT_BITS+1:0] trial;

	assign shifted = {rem_q, quo_q[prhm_pkg::RATE_BITS-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			prhm_pkg::DIV_IDLE: if (start) state_d = prhm_pkg::DIV_RUN;
			prhm_pkg::DIV_RUN:  if (step_q == prhm_pkg::LAST_STEP) state_d = prhm_pkg::DIV_DONE;
			prhm_pkg::DIV_DONE: if (ack) state_d = prhm_pkg::DIV_IDLE;
			default:            state_d = prhm_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = 1'b0;
		stat.done = 1'b0;
		case (state_q)
			prhm_pkg::DIV_IDLE: ;
			prhm_pkg::DIV_RUN:  stat.busy = 1'b1;
			prhm_pkg::DIV_DONE: stat.done = 1'b1;
			default:            ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prhm_pkg::DIV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == prhm_pkg::DIV_RUN)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == prhm_pkg::DIV_IDLE && start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (state_q == prhm_pkg::DIV_RUN) begin
			// remainder stays below den, so the low bits carry it
			if (!trial[prhm_pkg::COUNT_BITS+1])
				rem_q <= trial[prhm_pkg::COUNT_BITS-1:0];
			else
				rem_q <= shifted[prhm_pkg::COUNT_BITS-1:0];
			quo_q <= {quo_q[prhm_pkg::RATE_BITS-2:0], ~trial[prhm_pkg::COUNT_BITS+1]};
		end
	end

	assign quo = quo_q;

endmodule

>>> src/pulse_rate_hysteresis_meter_top.sv
// Top level of the pulse rate hysteresis meter.
// Usage: one converter sample per request on the input channel (in_valid /
// in_ready, field sample); one result per sample on the output channel
// (out_valid / out_ready, fields beat, armed_led, rate_x16).
// A sample that does not start a beat gives its result in the cycle after
// acceptance; the next sample can be taken in that same cycle.
// A sample that starts a beat runs the serial divider, a quotient bit per
// step, then waits in its done state until the output register is free;
// the result is registered at that hand-off, and the next sample is taken
// only after the divider is back to idle. The first beat (zero tick count)
// skips the divider and reports full-scale rate at once.
// Thresholds and samples_per_minute are written through cfg_we /
// cfg_addr / cfg_wdata; unknown indexes are ignored. The user must write
// them only while the block is idle; the block does not enforce this.
// Reset loads the default thresholds and rate scale, disarms the detector
// and clears tick count and held rate. A stalled receiver holds the result
// in the output register; a sample is taken only when it frees that cycle.
module pulse_rate_hysteresis_meter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [prhm_pkg::SAMPLE_BITS-1:0]    sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                beat,
	output logic                                armed_led,
	output logic [prhm_pkg::RATE_BITS-1:0]      rate_x16,
	input  logic                                cfg_we,
	input  logic [prhm_pkg::ADDR_BITS-1:0]      cfg_addr,
	input  logic [prhm_pkg::CFG_BITS-1:0]       cfg_wdata
);

	logic [prhm_pkg::LEVEL_BITS-1:0] rise_q, fall_q;
	logic [prhm_pkg::SPM_BITS-1:0]   spm_q;
	logic                            armed_q;
	logic [prhm_pkg::COUNT_BITS-1:0] tick_q;
	logic [prhm_pkg::RATE_BITS-1:0]  rate_q;

	logic                            out_valid_q;
	logic                            beat_q;
	logic                            led_q;
	logic [prhm_pkg::RATE_BITS-1:0]  rate_out_q;

	prhm_pkg::div_stat_t             div_stat;
	logic [prhm_pkg::RATE_BITS-1:0]  div_quo;

	logic out_free, accept, is_beat, is_fall, armed_next, div_start, div_ack;
	logic [prhm_pkg::CMP_BITS-1:0] s_ext;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !div_stat.busy && !div_stat.done && out_free;
	assign accept   = in_valid && in_ready;

	assign s_ext      = prhm_pkg::CMP_BITS'(sample);
	assign is_beat    = (s_ext > prhm_pkg::CMP_BITS'(rise_q)) && !armed_q;
	assign is_fall    = s_ext < prhm_pkg::CMP_BITS'(fall_q);
	assign armed_next = (armed_q || is_beat) && !is_fall;

	// zero count goes straight to full scale, no divide
	assign div_start = accept && is_beat && (tick_q != '0);
	assign div_ack   = div_stat.done && out_free;

	prhm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.ack    (div_ack),
		.num    ({spm_q, 4'b0000}),
		.den    (tick_q),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= prhm_pkg::RISE_RESET;
			fall_q <= prhm_pkg::FALL_RESET;
			spm_q  <= prhm_pkg::SPM_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				prhm_pkg::REG_RISE: rise_q <= cfg_wdata[prhm_pkg::LEVEL_BITS-1:0];
				prhm_pkg::REG_FALL: fall_q <= cfg_wdata[prhm_pkg::LEVEL_BITS-1:0];
				prhm_pkg::REG_SPM:  spm_q  <= cfg_wdata[prhm_pkg::SPM_BITS-1:0];
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			tick_q      <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				armed_q <= armed_next;
				if (is_beat)
					tick_q <= prhm_pkg::COUNT_BITS'(1);
				else if (tick_q != prhm_pkg::COUNT_MAX)
					tick_q <= tick_q + 1'b1;
				if (is_beat && tick_q == '0)
					rate_q <= prhm_pkg::RATE_MAX;
			end
			if (div_ack)
				rate_q <= div_quo;

			if (div_ack || (accept && !div_start))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ack) begin
			beat_q     <= 1'b1;
			led_q      <= armed_q;
			rate_out_q <= div_quo;
		end else if (accept && !div_start) begin
			beat_q     <= is_beat;
			led_q      <= armed_next;
			rate_out_q <= is_beat ? prhm_pkg::RATE_MAX : rate_q;
		end
	end

	assign out_valid = out_valid_q;
	assign beat      = beat_q;
	assign armed_led = led_q;
	assign rate_x16  = rate_out_q;

endmodule
